// File: rtl/core/wdhrb_pkg.sv
package wdhrb_pkg;

   // Access kinds carried in req_kind
   typedef enum logic [2:0] {
      KIND_REG_READ   = 3'd0,
      KIND_REG_WRITE  = 3'd1,
      KIND_WIN_WRITE  = 3'd2,
      KIND_RAM_READ   = 3'd3,
      KIND_RAM_WRITE  = 3'd4
   } kind_type;

   // Download handshake phases
   typedef enum logic [2:0] {
      PH_RESET     = 3'd0,
      PH_LOADING   = 3'd1,
      PH_RELEASED  = 3'd2,
      PH_PUBLISHED = 3'd3,
      PH_TRAINING  = 3'd4
   } phase_type;

   // Configuration register indexes
   localparam logic [2:0] CSR_CHIP_ID        = 3'd0;
   localparam logic [2:0] CSR_CHIP_REVISION  = 3'd1;
   localparam logic [2:0] CSR_HS_REVISION    = 3'd2;
   localparam logic [2:0] CSR_RAM_BASE       = 3'd3;
   localparam logic [2:0] CSR_RAM_SIZE       = 3'd4;
   localparam logic [2:0] CSR_POINTER_OFFSET = 3'd5;
   localparam logic [2:0] CSR_INFO_OFFSET    = 3'd6;

   // Register window size and register offsets
   localparam logic [22:0] REG_WINDOW_BYTES = 23'h004000;
   localparam logic [22:0] OFS_LINK_MASK    = 23'h000024;
   localparam logic [22:0] OFS_MB_STATUS    = 23'h000048;
   localparam logic [22:0] OFS_MB_MASK      = 23'h00004C;
   localparam logic [22:0] OFS_INT_STATUS   = 23'h000090;
   localparam logic [22:0] OFS_INT_MASK     = 23'h000094;
   localparam logic [22:0] OFS_HOST_MB      = 23'h000098;
   localparam logic [22:0] OFS_DOORBELL0    = 23'h000140;
   localparam logic [22:0] OFS_DOORBELL1    = 23'h000144;

   // Backplane decode constants
   localparam logic [31:0] ENUM_BASE      = 32'h2800_0000;
   localparam logic [31:0] ENUM_PTR_ADDR  = 32'h2800_00FC;
   localparam logic [31:0] TABLE_BASE     = 32'h2801_0000;
   localparam logic [31:0] DOORBELL_BITS  = 32'h0000_F000;
   localparam logic [31:0] D0_INFORM_BIT  = 32'h0000_0010;
   localparam logic [31:0] D3_ACK_BIT     = 32'h0000_0001;
   localparam logic [7:0]  TRAIN_SPAN     = 8'hFF;

   // Enumeration table, indexed by byte offset / 4
   localparam logic [31:0] ENUM_TABLE [4] = '{
      32'h43B8_0001, 32'h0000_0211, 32'h2800_0015, 32'h0000_000F
   };

   typedef struct packed {
      logic [15:0] chip_id;
      logic [3:0]  chip_revision;
      logic [7:0]  handshake_revision;
      logic [31:0] ram_base_address;
      logic [23:0] ram_size_bytes;
      logic [22:0] pointer_offset;
      logic [22:0] info_offset;
   } cfg_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [22:0] offset;
      logic [31:0] write_data;
      logic [2:0]  access_bytes;
   } item_type;

   typedef struct packed {
      logic [31:0] read_data;
      logic        raise_interrupt;
      logic        stamp_pointer;
      logic        stamp_header;
      logic [31:0] pointer_value;
      logic [2:0]  handshake_phase;
   } result_type;

endpackage

// File: rtl/core/wifi_dongle_host_register_block_top.sv
// Channel   Direction  Handshake              Payload
// req       in         req_valid / req_ready  kind, offset, write_data, access_bytes
// rsp       out        rsp_valid / rsp_ready  read_data, raise_interrupt, stamp_pointer,
//                                             stamp_header, pointer_value, handshake_phase
// csr       in         csr_valid / csr_ready  index, write_data (ready always high)
//
// One item per cycle sustained while rsp_ready is high; an accepted item waits in the
// input register, then moves to the result register, where rsp_valid shows it and the
// result can be taken.
// The whole access (decode, state update) is one pass of logic between the two.
// A stalled rsp stage holds its item; the input register keeps accepting while it is
// empty, or while the result register is empty or being drained.
// Reset (synchronous) empties both stages and restores engine state and configuration.
module wifi_dongle_host_register_block_top
   import wdhrb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_kind,
   input  logic [22:0] req_offset,
   input  logic [31:0] req_write_data,
   input  logic [2:0]  req_access_bytes,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_read_data,
   output logic        rsp_raise_interrupt,
   output logic        rsp_stamp_pointer,
   output logic        rsp_stamp_header,
   output logic [31:0] rsp_pointer_value,
   output logic [2:0]  rsp_handshake_phase,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_write_data
);

   cfg_type    cfg;
   item_type   item_ff, item_in;
   logic       item_valid_ff, item_valid_in;
   result_type result;
   result_type rsp_ff, rsp_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;
   logic       advance;

   assign csr_ready = 1'b1;

   wdhrb_csr u_csr (
      .clock          (clock),
      .reset          (reset),
      .csr_valid      (csr_valid),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .cfg            (cfg)
   );

   wdhrb_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .item      (item_ff),
      .item_fire (advance),
      .result    (result)
   );

   // Advance the held item when the result register can take it
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign advance   = item_valid_ff && out_free;
   assign req_ready = !item_valid_ff || out_free;

   always_comb begin
      item_valid_in = item_valid_ff;
      item_in       = item_ff;
      if (req_valid && req_ready) begin
         item_valid_in = 1'b1;
         item_in       = '{kind: req_kind, offset: req_offset,
                           write_data: req_write_data, access_bytes: req_access_bytes};
      end else if (advance) begin
         item_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
         rsp_in       = result;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control flags clear on reset; payload just loads
   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_read_data       = rsp_ff.read_data;
   assign rsp_raise_interrupt = rsp_ff.raise_interrupt;
   assign rsp_stamp_pointer   = rsp_ff.stamp_pointer;
   assign rsp_stamp_header    = rsp_ff.stamp_header;
   assign rsp_pointer_value   = rsp_ff.pointer_value;
   assign rsp_handshake_phase = rsp_ff.handshake_phase;

   // An item leaving the input register shows up as a result next cycle
   a_advance_to_rsp: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid)
      else $error("advanced item did not reach the result register");

   // An empty input register always takes an item
   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !item_valid_ff |-> req_ready)
      else $error("empty input stage not ready");

   // Pointer value only accompanies a pointer stamp
   a_pointer_gated: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stamp_pointer) |-> (rsp_pointer_value == 32'd0))
      else $error("pointer value without stamp");

   // Stamps are reported only with the published phase
   a_stamp_phase: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_stamp_pointer || rsp_stamp_header)) |->
      (rsp_handshake_phase == PH_PUBLISHED))
      else $error("stamp outside published phase");

endmodule

// File: rtl/core/wdhrb_csr.sv
module wdhrb_csr
   import wdhrb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_write_data,
   output cfg_type     cfg
);

   cfg_type cfg_ff, cfg_in;

   // Decode the write into the addressed field
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_CHIP_ID:        cfg_in.chip_id = csr_write_data[15:0];
            CSR_CHIP_REVISION:  cfg_in.chip_revision = csr_write_data[3:0];
            CSR_HS_REVISION:    cfg_in.handshake_revision = csr_write_data[7:0];
            CSR_RAM_BASE:       cfg_in.ram_base_address = csr_write_data;
            CSR_RAM_SIZE:       cfg_in.ram_size_bytes = csr_write_data[23:0];
            CSR_POINTER_OFFSET: cfg_in.pointer_offset = csr_write_data[22:0];
            CSR_INFO_OFFSET:    cfg_in.info_offset = csr_write_data[22:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   // Hold configuration, load reset values
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.chip_id            <= 16'h6717;
         cfg_ff.chip_revision      <= 4'h0;
         cfg_ff.handshake_revision <= 8'h06;
         cfg_ff.ram_base_address   <= 32'h0;
         cfg_ff.ram_size_bytes     <= 24'h40_0000;
         cfg_ff.pointer_offset     <= 23'h3F_FFFC;
         cfg_ff.info_offset        <= 23'h00_1000;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: rtl/core/wdhrb_engine.sv
module wdhrb_engine
   import wdhrb_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  item_type   item,
   input  logic       item_fire,
   output result_type result
);

   logic [31:0] window_ff, window_in;
   logic [31:0] int_status_ff, int_status_in;
   logic [31:0] int_mask_ff, int_mask_in;
   logic [31:0] mb_status_ff, mb_status_in;
   logic [31:0] mb_mask_ff, mb_mask_in;
   logic [31:0] link_mask_ff, link_mask_in;
   phase_type   phase_ff, phase_in;
   logic [31:0] count_ff, count_in;
   logic        stamped_ff, stamped_in;

   logic [31:0] bp_addr;
   logic [31:0] reg_value;
   logic [32:0] count_sum;
   logic        in_window;
   logic        train_hit;
   logic [24:0] ptr_end;
   logic [24:0] hdr_end;
   logic [23:0] train_end;

   assign bp_addr   = window_ff + {9'd0, item.offset};
   assign in_window = item.offset < REG_WINDOW_BYTES;
   assign count_sum = {1'b0, count_ff} + {30'd0, item.access_bytes};
   assign ptr_end   = {2'd0, cfg.pointer_offset} + 25'd4;
   assign hdr_end   = {2'd0, cfg.info_offset} + 25'd8;
   assign train_end = {1'b0, cfg.info_offset} + {16'd0, TRAIN_SPAN} + 24'd1;
   assign train_hit = (item.offset != cfg.pointer_offset) &&
                      (item.offset >= cfg.info_offset) &&
                      ({1'b0, item.offset} < train_end);

   // Decode a register read through the backplane window
   always_comb begin
      if (bp_addr == ENUM_BASE) begin
         reg_value = {3'd0, 1'b1, 4'h6, 4'h0, cfg.chip_revision, cfg.chip_id};
      end else if (bp_addr == ENUM_PTR_ADDR) begin
         reg_value = TABLE_BASE;
      end else if (bp_addr[31:4] == TABLE_BASE[31:4]) begin
         reg_value = ENUM_TABLE[bp_addr[3:2]];
      end else begin
         case (item.offset)
            OFS_INT_STATUS: reg_value = int_status_ff;
            OFS_INT_MASK:   reg_value = int_mask_ff;
            OFS_MB_STATUS:  reg_value = mb_status_ff;
            OFS_MB_MASK:    reg_value = mb_mask_ff;
            OFS_LINK_MASK:  reg_value = link_mask_ff;
            default:        reg_value = 32'd0;
         endcase
      end
   end

   // Work out the access: next state and result
   always_comb begin
      window_in     = window_ff;
      int_status_in = int_status_ff;
      int_mask_in   = int_mask_ff;
      mb_status_in  = mb_status_ff;
      mb_mask_in    = mb_mask_ff;
      link_mask_in  = link_mask_ff;
      phase_in      = phase_ff;
      count_in      = count_ff;
      stamped_in    = stamped_ff;
      result        = '0;
      case (item.kind)
         KIND_REG_READ: begin
            if (in_window) begin
               result.read_data = reg_value;
            end
         end
         KIND_REG_WRITE: begin
            if (in_window) begin
               case (item.offset)
                  OFS_INT_STATUS: int_status_in = int_status_ff & ~item.write_data;
                  OFS_INT_MASK:   int_mask_in = item.write_data;
                  OFS_MB_STATUS:  mb_status_in = mb_status_ff & ~item.write_data;
                  OFS_MB_MASK:    mb_mask_in = item.write_data;
                  OFS_LINK_MASK:  link_mask_in = item.write_data;
                  OFS_DOORBELL0, OFS_DOORBELL1: begin
                     mb_status_in           = mb_status_ff | DOORBELL_BITS;
                     int_status_in          = int_status_ff | DOORBELL_BITS;
                     result.raise_interrupt = 1'b1;
                  end
                  OFS_HOST_MB: begin
                     if ((item.write_data & D0_INFORM_BIT) != 32'd0) begin
                        mb_status_in           = mb_status_ff | D3_ACK_BIT;
                        int_status_in          = int_status_ff | D3_ACK_BIT;
                        result.raise_interrupt = 1'b1;
                     end
                  end
                  default: result.raise_interrupt = 1'b0;
               endcase
            end
         end
         KIND_WIN_WRITE: begin
            window_in = item.write_data;
            // Publish the shared header after a download
            if (phase_ff == PH_LOADING && count_ff != 32'd0) begin
               if (ptr_end <= {1'b0, cfg.ram_size_bytes}) begin
                  result.stamp_pointer = 1'b1;
                  result.pointer_value = cfg.ram_base_address + {9'd0, cfg.info_offset};
               end
               result.stamp_header = hdr_end <= {1'b0, cfg.ram_size_bytes};
               stamped_in          = 1'b1;
               phase_in            = PH_PUBLISHED;
            end
         end
         KIND_RAM_READ: begin
            if (train_hit && stamped_ff && phase_ff == PH_PUBLISHED) begin
               phase_in = PH_TRAINING;
            end
         end
         KIND_RAM_WRITE: begin
            // Count downloaded bytes, saturating
            if (phase_ff == PH_RESET || phase_ff == PH_LOADING) begin
               phase_in = PH_LOADING;
               count_in = count_sum[32] ? 32'hFFFF_FFFF : count_sum[31:0];
            end
         end
         default: phase_in = phase_ff;
      endcase
      result.handshake_phase = phase_in;
   end

   // Update state as the item leaves for the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff     <= ENUM_BASE;
         int_status_ff <= 32'd0;
         int_mask_ff   <= 32'd0;
         mb_status_ff  <= 32'd0;
         mb_mask_ff    <= 32'd0;
         link_mask_ff  <= 32'd0;
         phase_ff      <= PH_RESET;
         count_ff      <= 32'd0;
         stamped_ff    <= 1'b0;
      end else if (item_fire) begin
         window_ff     <= window_in;
         int_status_ff <= int_status_in;
         int_mask_ff   <= int_mask_in;
         mb_status_ff  <= mb_status_in;
         mb_mask_ff    <= mb_mask_in;
         link_mask_ff  <= link_mask_in;
         phase_ff      <= phase_in;
         count_ff      <= count_in;
         stamped_ff    <= stamped_in;
      end
   end

endmodule
